/* hw/rtl/rmsvw_pkg.sv */
// Shared constants and types for the RMS voltage window transfer block.
// Used by rmsvw_serial_mul and rms_voltage_window_transfer; no dependencies.

package rmsvw_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int COUNT_BITS_DEF  = 10;

   localparam int ADC_BITS    = 12;
   localparam int REQ_BITS    = 16;
   localparam int RSP_BITS    = 24;
   localparam int VOLT_BITS   = 16;
   localparam int MID_BITS    = 12;
   localparam int LEN_BITS    = 10;
   localparam int SUM_BITS    = 32;
   localparam int ROOT_BITS   = 16;
   localparam int MUL_BITS    = 16;
   localparam int STEP_BITS   = $clog2(SUM_BITS);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLTS_PER_CODE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DC_MIDPOINT    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LENGTH  = 3'd4;

   localparam logic [VOLT_BITS-1:0] LOW_THRESHOLD_RST  = 16'd22016;
   localparam logic [VOLT_BITS-1:0] HIGH_THRESHOLD_RST = 16'd32768;
   localparam logic [VOLT_BITS-1:0] VOLTS_PER_CODE_RST = 16'd5280;
   localparam logic [MID_BITS-1:0]  DC_MIDPOINT_RST    = 12'd2048;
   localparam logic [LEN_BITS-1:0]  WINDOW_LENGTH_RST  = 10'd200;

   typedef struct packed {
      logic                start;
      logic [MUL_BITS-1:0] a;
      logic [MUL_BITS-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                  done;
      logic [2*MUL_BITS-1:0] product;
   } mul_rsp_type;

endpackage

/* hw/rtl/rms_voltage_window_transfer.sv */
// RMS voltage window comparator with main/backup source selection, top level.
// Depends on rmsvw_pkg and rmsvw_serial_mul.
//
// Each req transaction carries one ADC sample; the midpoint is removed, the difference
// squared on a bit-serial multiplier and added to a saturating 32-bit sum. The next
// sample is not accepted until the 16-step serial multiplier has squared this one. The
// sample that closes a window adds a 32-step restoring divide by the sample count, a
// 16-step square root (two radicand bits per cycle) and a second 16-step multiply by
// volts_per_code, and then waits for the previous result to be taken. One rsp
// transaction per window carries the Q8.8 voltage, the window check and the selected
// source; a new sample is taken while a result waits in the output register. The csr
// port is always ready.

module rms_voltage_window_transfer #(
   parameter int SAMPLE_BITS = rmsvw_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = rmsvw_pkg::COUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rmsvw_pkg::REQ_BITS-1:0]       req_tdata,  // [11:0] adc_sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] voltage_q8, [16] in_range, [17] on_backup, [18] switched
   output logic [rmsvw_pkg::RSP_BITS-1:0]       rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rmsvw_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rmsvw_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int DW       = (SAMPLE_BITS > rmsvw_pkg::MID_BITS) ? SAMPLE_BITS
                                                                  : rmsvw_pkg::MID_BITS;
   localparam int NW       = COUNT_BITS + 1;
   localparam int CMPW     = (NW > rmsvw_pkg::LEN_BITS) ? NW : rmsvw_pkg::LEN_BITS;
   localparam int SB       = rmsvw_pkg::SUM_BITS;
   localparam int RB       = rmsvw_pkg::ROOT_BITS;
   localparam int VB       = rmsvw_pkg::VOLT_BITS;
   localparam int MB       = rmsvw_pkg::MUL_BITS;
   localparam int STW      = rmsvw_pkg::STEP_BITS;
   localparam int SQR_W    = RB + 1;
   localparam int SQT_W    = RB + 3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_DIVIDE,
      S_ROOT,
      S_SCALE,
      S_EMIT
   } state_type;

   state_type state_ff;

   logic [VB-1:0]                  low_ff;
   logic [VB-1:0]                  high_ff;
   logic [VB-1:0]                  vpc_ff;
   logic [rmsvw_pkg::MID_BITS-1:0] mid_ff;
   logic [rmsvw_pkg::LEN_BITS-1:0] len_ff;

   logic [SB-1:0]         sum_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic                  backup_ff;

   logic [SB-1:0]    work_ff;
   logic [NW-1:0]    rem_ff;
   logic [NW-1:0]    div_n_ff;
   logic [STW-1:0]   step_ff;
   logic [SQR_W-1:0] sq_rem_ff;
   logic [RB-1:0]    root_ff;
   logic [VB-1:0]    volts_ff;

   logic          rsp_valid_ff;
   logic [VB-1:0] rsp_volts_ff;
   logic          rsp_in_range_ff;
   logic          rsp_backup_ff;
   logic          rsp_switched_ff;

   rmsvw_pkg::mul_req_type mul_req;
   rmsvw_pkg::mul_rsp_type mul_rsp;

   logic          req_accept;
   logic [DW-1:0] sample;
   logic [DW-1:0] mid_w;
   logic [DW-1:0] diff;
   logic [SB:0]   sum_wide;
   logic [SB-1:0] sum_sat;
   logic [NW-1:0] n_next;
   logic          window_open;
   logic [NW:0]   div_shift;
   logic          div_ge;
   logic [NW-1:0] div_rem_next;
   logic [SQT_W-1:0] sq_cur;
   logic [SQT_W-1:0] sq_trial;
   logic          sq_ge;
   logic [RB-1:0] root_next;
   logic          in_window;
   logic          new_backup;
   logic          rsp_free;

   rmsvw_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign sample = DW'(req_tdata[rmsvw_pkg::ADC_BITS-1:0])
                   & ((DW'(1) << SAMPLE_BITS) - DW'(1));
   assign mid_w  = DW'(mid_ff);
   assign diff   = (sample >= mid_w) ? (sample - mid_w) : (mid_w - sample);

   assign sum_wide    = {1'b0, sum_ff} + (SB+1)'(mul_rsp.product);
   assign sum_sat     = sum_wide[SB] ? {SB{1'b1}} : sum_wide[SB-1:0];
   assign n_next      = NW'(count_ff) + NW'(1);
   assign window_open = (CMPW'(n_next) < CMPW'(len_ff)) && !n_next[COUNT_BITS];

   assign div_shift    = {rem_ff, work_ff[SB-1]};
   assign div_ge       = (div_shift >= {1'b0, div_n_ff});
   assign div_rem_next = div_ge ? NW'(div_shift - {1'b0, div_n_ff}) : NW'(div_shift);

   assign sq_cur    = {sq_rem_ff, work_ff[SB-1:SB-2]};
   assign sq_trial  = SQT_W'({root_ff, 2'b01});
   assign sq_ge     = (sq_cur >= sq_trial);
   assign root_next = {root_ff[RB-2:0], sq_ge};

   assign in_window  = (volts_ff >= low_ff) && (volts_ff <= high_ff);
   assign new_backup = !in_window;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      mul_req.start = 1'b0;
      mul_req.a     = vpc_ff;
      mul_req.b     = root_next;
      if (state_ff == S_IDLE) begin
         mul_req.start = req_accept;
         mul_req.a     = MB'(diff);
         mul_req.b     = MB'(diff);
      end else if (state_ff == S_ROOT && step_ff == STW'(RB-1)) begin
         mul_req.start = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= rmsvw_pkg::LOW_THRESHOLD_RST;
         high_ff <= rmsvw_pkg::HIGH_THRESHOLD_RST;
         vpc_ff  <= rmsvw_pkg::VOLTS_PER_CODE_RST;
         mid_ff  <= rmsvw_pkg::DC_MIDPOINT_RST;
         len_ff  <= rmsvw_pkg::WINDOW_LENGTH_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rmsvw_pkg::CSR_LOW_THRESHOLD:  low_ff  <= csr_data;
            rmsvw_pkg::CSR_HIGH_THRESHOLD: high_ff <= csr_data;
            rmsvw_pkg::CSR_VOLTS_PER_CODE: vpc_ff  <= csr_data;
            rmsvw_pkg::CSR_DC_MIDPOINT:    mid_ff  <= csr_data[rmsvw_pkg::MID_BITS-1:0];
            rmsvw_pkg::CSR_WINDOW_LENGTH:  len_ff  <= csr_data[rmsvw_pkg::LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         backup_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  state_ff <= S_SQUARE;
               end
            end
            S_SQUARE: begin
               if (mul_rsp.done) begin
                  if (window_open) begin
                     sum_ff   <= sum_sat;
                     count_ff <= n_next[COUNT_BITS-1:0];
                     state_ff <= S_IDLE;
                  end else begin
                     sum_ff   <= '0;
                     count_ff <= '0;
                     work_ff  <= sum_sat;
                     rem_ff   <= '0;
                     div_n_ff <= n_next;
                     step_ff  <= '0;
                     state_ff <= S_DIVIDE;
                  end
               end
            end
            S_DIVIDE: begin
               work_ff <= {work_ff[SB-2:0], div_ge};
               rem_ff  <= div_rem_next;
               step_ff <= step_ff + STW'(1);
               if (step_ff == STW'(SB-1)) begin
                  sq_rem_ff <= '0;
                  root_ff   <= '0;
                  step_ff   <= '0;
                  state_ff  <= S_ROOT;
               end
            end
            S_ROOT: begin
               work_ff   <= {work_ff[SB-3:0], 2'b00};
               sq_rem_ff <= sq_ge ? SQR_W'(sq_cur - sq_trial) : SQR_W'(sq_cur);
               root_ff   <= root_next;
               step_ff   <= step_ff + STW'(1);
               if (step_ff == STW'(RB-1)) begin
                  step_ff  <= '0;
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               if (mul_rsp.done) begin
                  volts_ff <= (|mul_rsp.product[2*MB-1:VB+8]) ? {VB{1'b1}}
                                                              : mul_rsp.product[VB+7:8];
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_volts_ff    <= volts_ff;
                  rsp_in_range_ff <= in_window;
                  rsp_backup_ff   <= new_backup;
                  rsp_switched_ff <= (new_backup != backup_ff);
                  backup_ff       <= new_backup;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_switched_ff, rsp_backup_ff, rsp_in_range_ff, rsp_volts_ff};

`ifndef SYNTHESIS
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == S_SQUARE || state_ff == S_SCALE))
      else $error("multiplier result outside a waiting state");

   a_accept_starts_square: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_SQUARE))
      else $error("accepted sample did not start squaring");

   a_source_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_backup_ff == backup_ff))
      else $error("pending result disagrees with selected source");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT))
      else $error("result raised outside emit");
`endif

endmodule

/* hw/rtl/rmsvw_serial_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on rmsvw_pkg for widths and request/response structs.

module rmsvw_serial_mul (
   input  logic                   clock,
   input  logic                   reset,
   input  rmsvw_pkg::mul_req_type mul_req,
   output rmsvw_pkg::mul_rsp_type mul_rsp
);

   localparam int W      = rmsvw_pkg::MUL_BITS;
   localparam int CNT_W  = $clog2(W);

   logic [2*W-1:0]   acc_ff;
   logic [W-1:0]     mcand_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [W:0]       part_sum;

   assign part_sum = {1'b0, acc_ff[2*W-1:W]} + {1'b0, (acc_ff[0] ? mcand_ff : W'(0))};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            acc_ff   <= {W'(0), mul_req.b};
            mcand_ff <= mul_req.a;
            cnt_ff   <= '0;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            acc_ff <= {part_sum, acc_ff[W-1:1]};
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(W-1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

/* dv/rms_voltage_window_transfer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rms_voltage_window_transfer: RMS windows, thresholds, source select.
// Needs rmsvw_pkg and the block's RTL; a scoreboard class predicts every window result.

module rms_voltage_window_transfer_tb;

   localparam int SETTLE_CYCLES = 120;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 1680;
   localparam int COUNT_CEILING = 1 << rmsvw_pkg::COUNT_BITS_DEF;
   localparam logic [rmsvw_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic [rmsvw_pkg::VOLT_BITS-1:0] voltage_q8;
      logic                            in_range;
      logic                            on_backup;
      logic                            switched;
   } window_result_type;

   class window_voltage_predictor;
      logic [rmsvw_pkg::VOLT_BITS-1:0] low_thr;
      logic [rmsvw_pkg::VOLT_BITS-1:0] high_thr;
      logic [rmsvw_pkg::VOLT_BITS-1:0] volts_per_code;
      logic [rmsvw_pkg::MID_BITS-1:0]  midpoint;
      logic [rmsvw_pkg::LEN_BITS-1:0]  window_len;
      logic [rmsvw_pkg::SUM_BITS-1:0]  square_sum;
      int unsigned                     filled;
      logic                            backup;
      window_result_type               pending_windows[$];
      int unsigned                     windows_seen;
      int unsigned                     mismatches;

      function new();
         low_thr        = rmsvw_pkg::LOW_THRESHOLD_RST;
         high_thr       = rmsvw_pkg::HIGH_THRESHOLD_RST;
         volts_per_code = rmsvw_pkg::VOLTS_PER_CODE_RST;
         midpoint       = rmsvw_pkg::DC_MIDPOINT_RST;
         window_len     = rmsvw_pkg::WINDOW_LENGTH_RST;
         square_sum     = '0;
         filled         = 0;
         backup         = 1'b0;
         windows_seen   = 0;
         mismatches     = 0;
      endfunction

      function void write_reg(logic [rmsvw_pkg::CSR_INDEX_BITS-1:0] index,
                              logic [rmsvw_pkg::CSR_DATA_BITS-1:0] data);
         case (index)
            rmsvw_pkg::CSR_LOW_THRESHOLD: low_thr = data;
            rmsvw_pkg::CSR_HIGH_THRESHOLD: high_thr = data;
            rmsvw_pkg::CSR_VOLTS_PER_CODE: volts_per_code = data;
            rmsvw_pkg::CSR_DC_MIDPOINT: midpoint = data[rmsvw_pkg::MID_BITS-1:0];
            rmsvw_pkg::CSR_WINDOW_LENGTH: window_len = data[rmsvw_pkg::LEN_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [rmsvw_pkg::ROOT_BITS-1:0] floor_root(
         logic [rmsvw_pkg::SUM_BITS-1:0] value);
         logic [rmsvw_pkg::ROOT_BITS-1:0] root;
         logic [rmsvw_pkg::ROOT_BITS-1:0] trial;
         logic [rmsvw_pkg::SUM_BITS-1:0]  square;
         int                              b;
         root = '0;
         for (b = rmsvw_pkg::ROOT_BITS - 1; b >= 0; b--) begin
            trial  = root | (rmsvw_pkg::ROOT_BITS'(1) << b);
            square = trial * trial;
            if (square <= value) root = trial;
         end
         return root;
      endfunction

      function void take_sample(logic [rmsvw_pkg::ADC_BITS-1:0] adc);
         logic [rmsvw_pkg::ADC_BITS-1:0]   diff;
         logic [rmsvw_pkg::SUM_BITS+1:0]   total;
         logic [rmsvw_pkg::SUM_BITS-1:0]   sum_sat;
         logic [rmsvw_pkg::SUM_BITS-1:0]   mean;
         logic [rmsvw_pkg::ROOT_BITS-1:0]  root;
         logic [2*rmsvw_pkg::MUL_BITS-1:0] product;
         logic [rmsvw_pkg::VOLT_BITS-1:0]  volts;
         int unsigned                      n;
         window_result_type                r;
         diff    = (adc >= midpoint) ? adc - midpoint : midpoint - adc;
         total   = {2'b00, square_sum} + diff * diff;
         sum_sat = (total > {2'b00, {rmsvw_pkg::SUM_BITS{1'b1}}}) ? '1
                                                                   : total[rmsvw_pkg::SUM_BITS-1:0];
         n       = filled + 1;
         if (n < window_len && n < COUNT_CEILING) begin
            square_sum = sum_sat;
            filled     = n;
            return;
         end
         mean    = sum_sat / n;
         root    = floor_root(mean);
         product = root * volts_per_code;
         volts   = (product[2*rmsvw_pkg::MUL_BITS-1:8] > 'hFFFF) ? '1
                                                                 : product[rmsvw_pkg::VOLT_BITS+7:8];
         r.voltage_q8 = volts;
         r.in_range   = (volts >= low_thr) && (volts <= high_thr);
         r.on_backup  = !r.in_range;
         r.switched   = r.on_backup != backup;
         backup       = r.on_backup;
         square_sum   = '0;
         filled       = 0;
         pending_windows.push_back(r);
      endfunction

      function void compare_field(string name, logic [rmsvw_pkg::VOLT_BITS-1:0] want,
                                  logic [rmsvw_pkg::VOLT_BITS-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_window(logic [rmsvw_pkg::RSP_BITS-1:0] data);
         window_result_type want;
         if (pending_windows.size() == 0) begin
            $error("window result with none pending: tdata %h", data);
            mismatches++;
            return;
         end
         want = pending_windows.pop_front();
         windows_seen++;
         compare_field("voltage_q8", want.voltage_q8, data[rmsvw_pkg::VOLT_BITS-1:0]);
         compare_field("in_range", rmsvw_pkg::VOLT_BITS'(want.in_range),
                       rmsvw_pkg::VOLT_BITS'(data[rmsvw_pkg::VOLT_BITS]));
         compare_field("on_backup", rmsvw_pkg::VOLT_BITS'(want.on_backup),
                       rmsvw_pkg::VOLT_BITS'(data[rmsvw_pkg::VOLT_BITS+1]));
         compare_field("switched", rmsvw_pkg::VOLT_BITS'(want.switched),
                       rmsvw_pkg::VOLT_BITS'(data[rmsvw_pkg::VOLT_BITS+2]));
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [rmsvw_pkg::REQ_BITS-1:0]       req_tdata = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [rmsvw_pkg::RSP_BITS-1:0]       rsp_tdata;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [rmsvw_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [rmsvw_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;

   window_voltage_predictor predictor = new();
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned items_sent = 0;
   int unsigned settings_applied = 0;
   int unsigned cycles = 0;

   rms_voltage_window_transfer DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) predictor.check_window(rsp_tdata);
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic set_pace(input int unsigned mode);
      case (mode % 4)
         0: begin gap_pct = 0;  stall_pct <= 0;  end
         1: begin gap_pct = 53; stall_pct <= 0;  end
         2: begin gap_pct = 0;  stall_pct <= 53; end
         default: begin gap_pct = 9; stall_pct <= 9; end
      endcase
   endtask

   // sender holds off until every predicted window has been received
   task automatic drain();
      if (predictor.pending_windows.size() != 0) begin
         req_tvalid <= 1'b0;
         while (predictor.pending_windows.size() != 0) @(posedge clock);
      end
   endtask

   // a sample that closes no window may still be in flight
   task automatic settle();
      req_tvalid <= 1'b0;
      while (predictor.pending_windows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [rmsvw_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [rmsvw_pkg::CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      predictor.write_reg(index, data);
   endtask

   task automatic apply_settings(input logic [rmsvw_pkg::VOLT_BITS-1:0] low,
                                 input logic [rmsvw_pkg::VOLT_BITS-1:0] high,
                                 input logic [rmsvw_pkg::VOLT_BITS-1:0] scale,
                                 input logic [rmsvw_pkg::MID_BITS-1:0] mid,
                                 input logic [rmsvw_pkg::LEN_BITS-1:0] len);
      settle();
      write_csr(rmsvw_pkg::CSR_LOW_THRESHOLD, low);
      write_csr(rmsvw_pkg::CSR_HIGH_THRESHOLD, high);
      write_csr(rmsvw_pkg::CSR_VOLTS_PER_CODE, scale);
      write_csr(rmsvw_pkg::CSR_DC_MIDPOINT, rmsvw_pkg::CSR_DATA_BITS'(mid));
      write_csr(rmsvw_pkg::CSR_WINDOW_LENGTH, rmsvw_pkg::CSR_DATA_BITS'(len));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic send_sample(input logic [rmsvw_pkg::ADC_BITS-1:0] adc);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rmsvw_pkg::REQ_BITS'(adc);
      do @(posedge clock); while (!req_tready);
      predictor.take_sample(adc);
      items_sent++;
   endtask

   // loud: samples far from a zero midpoint so the square sum saturates
   task automatic run_phase(input int unsigned count, input bit loud);
      int unsigned amp;
      int unsigned k;
      int          v;
      amp = 0;
      for (k = 0; k < count; k++) begin
         if (predictor.filled == 0)
            amp = ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(0, 2047);
         if ($urandom_range(0, 15) == 0) begin
            v = $urandom_range(0, 4095);
         end else if (loud) begin
            v = $urandom_range(3200, 4095);
         end else begin
            v = $urandom_range(0, amp);
            v = $urandom_range(0, 1) ? int'(predictor.midpoint) + v
                                     : int'(predictor.midpoint) - v;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
         end
         if ($urandom_range(0, 149) == 0) drain();
         send_sample(rmsvw_pkg::ADC_BITS'(v));
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned random_start;
      int          lo;
      int          hi;
      int          len;
      int          mid;
      int          scale;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_pace(0);

      // directed: saturation, zero and tiny voltages at full scale
      apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 12'd2048, 10'd1);
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'd2048);
      send_sample(12'd2049);
      // narrow window: out, in, out again
      apply_settings(16'd256, 16'd1000, 16'hFFFF, 12'd2048, 10'd1);
      send_sample(12'd2048);
      send_sample(12'd2050);
      send_sample(12'd2060);
      // inverted thresholds with zero window length
      apply_settings(16'd5000, 16'd4000, 16'hFFFF, 12'd2048, 10'd0);
      send_sample(12'd2065);
      send_sample(12'd0);
      settle();
      write_csr(CSR_SPARE, '1);
      csr_valid <= 1'b0;
      apply_settings(16'd0, 16'hFFFF, 16'd0, 12'd0, 10'd1);
      send_sample(12'd4095);
      apply_settings(16'd0, 16'hFFFF, 16'd300, 12'd4095, 10'd1);
      send_sample(12'd0);
      // window length lowered part way through a window
      apply_settings(rmsvw_pkg::LOW_THRESHOLD_RST, rmsvw_pkg::HIGH_THRESHOLD_RST,
                     rmsvw_pkg::VOLTS_PER_CODE_RST, rmsvw_pkg::DC_MIDPOINT_RST, 10'd5);
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'd100);
      apply_settings(rmsvw_pkg::LOW_THRESHOLD_RST, rmsvw_pkg::HIGH_THRESHOLD_RST,
                     rmsvw_pkg::VOLTS_PER_CODE_RST, rmsvw_pkg::DC_MIDPOINT_RST, 10'd2);
      send_sample(12'd3000);

      random_start = items_sent;
      apply_settings(rmsvw_pkg::LOW_THRESHOLD_RST, rmsvw_pkg::HIGH_THRESHOLD_RST,
                     rmsvw_pkg::VOLTS_PER_CODE_RST, rmsvw_pkg::DC_MIDPOINT_RST,
                     rmsvw_pkg::WINDOW_LENGTH_RST);
      run_phase(200, 1'b0);

      set_pace(1);
      apply_settings(16'd20000, 16'd30000, 16'd3000, 12'd0, 10'd1023);
      run_phase(1023, 1'b1);

      phase = 2;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         set_pace(phase);
         lo = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 30000);
         case ($urandom_range(0, 7))
            0: hi = 65535;
            1: hi = $urandom_range(0, lo);
            default: hi = lo + $urandom_range(0, 25000);
         endcase
         if (hi > 65535) hi = 65535;
         case ($urandom_range(0, 9))
            0: scale = 0;
            1: scale = 65535;
            default: scale = $urandom_range(2000, 16000);
         endcase
         case ($urandom_range(0, 5))
            0: mid = 0;
            1: mid = 4095;
            default: mid = $urandom_range(1500, 2600);
         endcase
         case ($urandom_range(0, 9))
            0: len = 0;
            1: len = 1;
            default: len = $urandom_range(2, 24);
         endcase
         apply_settings(rmsvw_pkg::VOLT_BITS'(lo), rmsvw_pkg::VOLT_BITS'(hi),
                        rmsvw_pkg::VOLT_BITS'(scale), rmsvw_pkg::MID_BITS'(mid),
                        rmsvw_pkg::LEN_BITS'(len));
         run_phase($urandom_range(40, 80), 1'b0);
         phase++;
      end

      settle();
      $display("%0d samples sent under %0d register settings, %0d windows compared",
               items_sent, settings_applied, predictor.windows_seen);
      if (predictor.mismatches == 0 && predictor.pending_windows.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
